>>> src/amf3fu_pkg.sv
// ----------------------------------------------------------------------------
// amf3fu_pkg
// Shared types and codes of the AMF3 primitive field unpacker.
// ----------------------------------------------------------------------------
package amf3fu_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned CNT_W    = 4;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    // field kinds
    localparam kind_t KIND_BYTE     = 3'd0;
    localparam kind_t KIND_U29_S    = 3'd1;
    localparam kind_t KIND_INT32    = 3'd2;
    localparam kind_t KIND_U29_U    = 3'd3;
    localparam kind_t KIND_U32      = 3'd4;
    localparam kind_t KIND_DOUBLE   = 3'd5;
    localparam kind_t KIND_STR_U29  = 3'd6;
    localparam kind_t KIND_STR_U32  = 3'd7;

    // result status codes
    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_SHORT    = 2'd1;
    localparam status_t STATUS_EOD_IDLE = 2'd2;

    // bytes in a fixed-size field
    localparam cnt_t LEN_WORD   = 4'd4;
    localparam cnt_t LEN_DOUBLE = 4'd8;
    // the fourth varint byte carries a full 8 bits
    localparam cnt_t VARINT_LAST_IDX = 4'd3;
    localparam cnt_t VARINT_MAX      = 4'd4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HEAD = 2'd1,
        PH_PAY  = 2'd2
    } phase_t;

endpackage

>>> src/amf3fu_in_if.sv
// ----------------------------------------------------------------------------
// amf3fu_in_if
// Byte request channel: one encoded byte with its field kind per request.
// ----------------------------------------------------------------------------
interface amf3fu_in_if
    import amf3fu_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t data_byte;
    kind_t field_kind;
    logic  end_of_data;

    modport source (
        output valid, data_byte, field_kind, end_of_data,
        input  ready
    );

    modport sink (
        input  valid, data_byte, field_kind, end_of_data,
        output ready
    );
endinterface

>>> src/amf3fu_out_if.sv
// ----------------------------------------------------------------------------
// amf3fu_out_if
// Result request channel: one decoded value, header or payload byte.
// ----------------------------------------------------------------------------
interface amf3fu_out_if
    import amf3fu_pkg::*;
;
    logic    valid;
    logic    ready;
    value_t  value;
    kind_t   kind_out;
    logic    is_payload;
    logic    last;
    status_t status;
    pos_t    position;

    modport source (
        output valid, value, kind_out, is_payload, last, status, position,
        input  ready
    );

    modport sink (
        input  valid, value, kind_out, is_payload, last, status, position,
        output ready
    );
endinterface

>>> src/amf3_primitive_field_unpacker_top.sv
// ----------------------------------------------------------------------------
// amf3_primitive_field_unpacker_top
// Decodes AMF3 primitive fields from a byte stream, one byte per request.
// ----------------------------------------------------------------------------
// Usage: each request on stream carries one byte and the kind of field it
// starts (the kind is only looked at on the first byte of a field). Raw bytes,
// U29 varints (signed and unsigned), 32-bit integers, doubles (raw bits) and
// strings with U29 or U32 length are decoded. A scalar yields one result on
// its final byte; a string yields its length header and then one result per
// payload byte. An end_of_data request always yields a result: status 1 if a
// field was cut short (the field is dropped), status 2 if the block was idle.
// Throughput is one request per cycle except under backpressure on result:
// stream.ready is high whenever the result register is empty or being drained
// in the same cycle. Each accepted request is decoded by a single layer of
// logic into the result register, so its result (if any) appears in the next
// cycle. position counts bytes consumed and saturates.
// ----------------------------------------------------------------------------
module amf3_primitive_field_unpacker_top
    import amf3fu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    amf3fu_in_if.sink    stream,
    amf3fu_out_if.source result
);

    // decoder state
    phase_t phase_reg,  phase_next;
    cnt_t   fbc_reg,    fbc_next;
    value_t acc_reg,    acc_next;
    pos_t   rem_reg,    rem_next;
    kind_t  kind_reg,   kind_next;
    pos_t   pos_reg,    pos_next;

    // result register
    logic    out_valid_reg, out_valid_next;
    value_t  value_reg,     value_next;
    kind_t   kind_out_reg,  kind_out_next;
    logic    payload_reg,   payload_next;
    logic    last_reg,      last_next;
    status_t status_reg,    status_next;
    pos_t    position_reg,  position_next;

    logic   accept;
    logic   res_fire;
    logic   busy;
    kind_t  k;
    cnt_t   f;
    cnt_t   f_inc;
    value_t a;
    value_t a_new;
    cnt_t   f_new;
    logic   done;
    value_t v;
    pos_t   rem_dec;

    // result register drains or is empty -> take a new byte
    assign stream.ready = !out_valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;

    assign result.valid      = out_valid_reg;
    assign result.value      = value_reg;
    assign result.kind_out   = kind_out_reg;
    assign result.is_payload = payload_reg;
    assign result.last       = last_reg;
    assign result.status     = status_reg;
    assign result.position   = position_reg;

    // phase 3 is never entered and counts as idle
    assign busy    = (phase_reg == PH_HEAD) || (phase_reg == PH_PAY);
    assign rem_dec = rem_reg - pos_t'(1);

    // kind and accumulator in force for this byte
    assign k     = busy ? kind_reg : stream.field_kind;
    assign f     = busy ? fbc_reg  : '0;
    assign a     = busy ? acc_reg  : '0;
    assign f_inc = f + cnt_t'(1);

    // absorb one byte
    always_comb
    begin
        if (k inside {KIND_U29_S, KIND_U29_U, KIND_STR_U29}) begin
            if (f >= VARINT_LAST_IDX) begin
                a_new = {a[VALUE_W-9:0], stream.data_byte};
                f_new = VARINT_MAX;
                done  = 1'b1;
            end else begin
                a_new = {a[VALUE_W-8:0], stream.data_byte[6:0]};
                f_new = f_inc;
                done  = !stream.data_byte[7];
            end
        end else begin
            a_new = {a[VALUE_W-9:0], stream.data_byte};
            f_new = f_inc;
            done  = f_inc >= ((k == KIND_DOUBLE) ? LEN_DOUBLE : LEN_WORD);
        end
    end

    // final value of a completed field
    always_comb
    begin
        case (k)
            KIND_U29_S:               v = {{35{a_new[28]}}, a_new[28:0]};
            KIND_INT32:               v = {{32{a_new[31]}}, a_new[31:0]};
            KIND_U29_U, KIND_STR_U29: v = {35'd0, a_new[28:0]};
            KIND_U32, KIND_STR_U32:   v = {32'd0, a_new[31:0]};
            default:                  v = a_new;
        endcase
    end

    // next state and result
    always_comb
    begin
        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        kind_next  = kind_reg;
        pos_next   = pos_reg;

        res_fire      = 1'b0;
        value_next    = '0;
        kind_out_next = k;
        payload_next  = 1'b0;
        last_next     = 1'b1;
        status_next   = STATUS_OK;

        if (accept) begin
            if (stream.end_of_data) begin
                res_fire = 1'b1;
                if (busy) begin
                    kind_out_next = kind_reg;
                    status_next   = STATUS_SHORT;
                    phase_next    = PH_IDLE;
                    fbc_next      = '0;
                    acc_next      = '0;
                    rem_next      = '0;
                end else begin
                    kind_out_next = stream.field_kind;
                    status_next   = STATUS_EOD_IDLE;
                end
            end else begin
                if (pos_reg != '1) begin
                    pos_next = pos_reg + pos_t'(1);
                end
                if (phase_reg == PH_PAY) begin
                    // string payload byte passes through
                    res_fire      = 1'b1;
                    rem_next      = rem_dec;
                    value_next    = {56'd0, stream.data_byte};
                    kind_out_next = kind_reg;
                    payload_next  = 1'b1;
                    last_next     = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        phase_next = PH_IDLE;
                    end
                end else if (!busy && stream.field_kind == KIND_BYTE) begin
                    res_fire      = 1'b1;
                    value_next    = {56'd0, stream.data_byte};
                    kind_out_next = KIND_BYTE;
                    kind_next     = KIND_BYTE;
                    phase_next    = PH_IDLE;
                    fbc_next      = '0;
                    acc_next      = '0;
                    rem_next      = '0;
                end else begin
                    kind_next = k;
                    if (!busy) begin
                        rem_next = '0;
                    end
                    if (done) begin
                        res_fire   = 1'b1;
                        value_next = v;
                        fbc_next   = '0;
                        acc_next   = '0;
                        phase_next = PH_IDLE;
                        if (k == KIND_STR_U29 || k == KIND_STR_U32) begin
                            rem_next  = v[POS_W-1:0];
                            last_next = (v[POS_W-1:0] == '0);
                            if (v[POS_W-1:0] != '0) begin
                                phase_next = PH_PAY;
                            end
                        end
                    end else begin
                        phase_next = PH_HEAD;
                        fbc_next   = f_new;
                        acc_next   = a_new;
                    end
                end
            end
        end

        position_next = pos_next;

        if (res_fire) begin
            out_valid_next = 1'b1;
        end else if (result.ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            fbc_reg       <= '0;
            acc_reg       <= '0;
            rem_reg       <= '0;
            kind_reg      <= KIND_BYTE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            fbc_reg       <= fbc_next;
            acc_reg       <= acc_next;
            rem_reg       <= rem_next;
            kind_reg      <= kind_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when a result is produced
    always_ff @(posedge clk)
    begin
        if (res_fire) begin
            value_reg    <= value_next;
            kind_out_reg <= kind_out_next;
            payload_reg  <= payload_next;
            last_reg     <= last_next;
            status_reg   <= status_next;
            position_reg <= position_next;
        end
    end

endmodule

>>> tb/amf3_primitive_field_unpacker_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// amf3_primitive_field_unpacker_top_test
// Self-checking bench for the AMF3 primitive field unpacker: directed fields
// (extreme values, early varint end, empty string, cut-short fields, end of
// data while idle) and then a long random stream of well-formed fields mixed
// with truncated ones. Results are checked against an in-bench decoder model.
// ----------------------------------------------------------------------------
module amf3_primitive_field_unpacker_top_test
    import amf3fu_pkg::*;
;

    localparam int STALL_LIMIT   = 1000;  // cycles with no request moving on either side
    localparam int RANDOM_ITEMS  = 610;   // random requests per idling phase
    localparam int DRAIN_CYCLES  = 8;     // settle time after the last result
    localparam int MAX_REPORTS   = 10;

    // one decoded result as it leaves the block
    typedef struct packed {
        value_t  value;
        kind_t   kind;
        logic    is_payload;
        logic    last;
        status_t status;
        pos_t    position;
    } result_t;

    logic clk;
    logic rst_n;

    amf3fu_in_if  byte_ch ();
    amf3fu_out_if result_ch ();

    amf3_primitive_field_unpacker_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (byte_ch),
        .result (result_ch)
    );

    // decoder model state
    phase_t  dec_phase;
    cnt_t    dec_count;
    value_t  dec_acc;
    pos_t    dec_remaining;
    kind_t   dec_kind;
    pos_t    dec_pos;

    // results the decoder model has produced and the block still owes
    result_t pending_results[$];

    // idling in percent of cycles, changed per phase
    int send_idle_pct;
    int recv_idle_pct;

    // run statistics
    int requests_sent;
    int results_seen;
    int payload_seen;
    int short_seen;
    int idle_eod_seen;
    int longest_string;
    int mismatches;

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // decoder model: applies one accepted request, returns 1 with the result
    // when the request completes something
    // ------------------------------------------------------------------------
    function automatic bit decode_request(input byte_t b, input kind_t k_in, input logic eod,
                                          output result_t r);
        logic   busy;
        logic   done;
        logic   varint;
        value_t v;
        cnt_t   need;

        busy = (dec_phase == PH_HEAD) || (dec_phase == PH_PAY);
        r = '0;

        // end of data never consumes a byte, so the position stays put
        if (eod)
        begin
            r.last     = 1'b1;
            r.position = dec_pos;
            if (busy)
            begin
                // field cut short: dropped, block goes idle
                r.kind        = dec_kind;
                r.status      = STATUS_SHORT;
                dec_phase     = PH_IDLE;
                dec_count     = '0;
                dec_acc       = '0;
                dec_remaining = '0;
            end
            else
            begin
                r.kind   = k_in;
                r.status = STATUS_EOD_IDLE;
            end
            return 1'b1;
        end

        // position saturates at all ones
        if (dec_pos != '1)
            dec_pos = dec_pos + pos_t'(1);

        // string payload passes straight through
        if (dec_phase == PH_PAY)
        begin
            dec_remaining = dec_remaining - pos_t'(1);
            if (dec_remaining == 0)
                dec_phase = PH_IDLE;
            r.value      = value_t'(b);
            r.kind       = dec_kind;
            r.is_payload = 1'b1;
            r.last       = (dec_remaining == 0);
            r.status     = STATUS_OK;
            r.position   = dec_pos;
            return 1'b1;
        end

        // first byte of a field latches the kind
        if (!busy)
        begin
            dec_kind      = k_in;
            dec_count     = '0;
            dec_acc       = '0;
            dec_remaining = '0;
            if (k_in == KIND_BYTE)
            begin
                dec_phase  = PH_IDLE;
                r.value    = value_t'(b);
                r.kind     = KIND_BYTE;
                r.last     = 1'b1;
                r.status   = STATUS_OK;
                r.position = dec_pos;
                return 1'b1;
            end
            dec_phase = PH_HEAD;
        end

        varint = (dec_kind == KIND_U29_S) || (dec_kind == KIND_U29_U) ||
                 (dec_kind == KIND_STR_U29);
        if (varint)
        begin
            if (dec_count >= VARINT_LAST_IDX)
            begin
                // fourth varint byte carries all 8 bits
                dec_acc   = (dec_acc << 8) | value_t'(b);
                dec_count = VARINT_MAX;
                done      = 1'b1;
            end
            else
            begin
                dec_acc   = (dec_acc << 7) | value_t'(b[6:0]);
                dec_count = dec_count + cnt_t'(1);
                done      = !b[7];
            end
        end
        else
        begin
            need      = (dec_kind == KIND_DOUBLE) ? LEN_DOUBLE : LEN_WORD;
            dec_acc   = (dec_acc << 8) | value_t'(b);
            dec_count = dec_count + cnt_t'(1);
            done      = (dec_count >= need);
        end

        if (!done)
            return 1'b0;

        // field complete: shape the value by kind
        v         = dec_acc;
        dec_phase = PH_IDLE;
        dec_count = '0;
        dec_acc   = '0;
        case (dec_kind)
            KIND_U29_S:
            begin
                v = v & 64'h1fff_ffff;
                if (v[28])
                    v = v - 64'h2000_0000;
            end
            KIND_INT32:                 v = {{32{v[31]}}, v[31:0]};
            KIND_U29_U, KIND_STR_U29:   v = v & 64'h1fff_ffff;
            KIND_U32, KIND_STR_U32:     v = v & 64'hffff_ffff;
            default:                    v = v;
        endcase

        r.value    = v;
        r.kind     = dec_kind;
        r.status   = STATUS_OK;
        r.position = dec_pos;
        r.last     = 1'b1;
        if ((dec_kind == KIND_STR_U29) || (dec_kind == KIND_STR_U32))
        begin
            // length header; an empty string ends right here
            dec_remaining = v[31:0];
            if (dec_remaining != 0)
                dec_phase = PH_PAY;
            r.last = (dec_remaining == 0);
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // request side: one request per call, held until the block takes it
    // ------------------------------------------------------------------------
    task automatic send_req(input byte_t b, input kind_t k, input logic eod);
        result_t r;

        // random gap before the request, valid low meanwhile
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= b;
        byte_ch.field_kind  <= k;
        byte_ch.end_of_data <= eod;
        // valid stays high on return so back-to-back requests need no toggle
        do
            @(posedge clk);
        while (!byte_ch.ready);
        requests_sent++;
        if (decode_request(b, k, eod, r))
            pending_results.push_back(r);
    endtask

    // sends the low n bytes of a packed word, most significant first; later
    // bytes carry a random kind, which the block must ignore mid-field
    task automatic send_be(input kind_t k, input value_t bytes, input int n);
        for (int i = n - 1; i >= 0; i--)
            send_req(bytes[i*8 +: 8], (i == n - 1) ? k : kind_t'($urandom_range(7)), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // result side: check every accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_checker
        result_t got;
        result_t want;

        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.value      = result_ch.value;
            got.kind       = result_ch.kind_out;
            got.is_payload = result_ch.is_payload;
            got.last       = result_ch.last;
            got.status     = result_ch.status;
            got.position   = result_ch.position;
            results_seen++;
            if (got.is_payload)
                payload_seen++;
            if (got.status == STATUS_SHORT)
                short_seen++;
            if (got.status == STATUS_EOD_IDLE)
                idle_eod_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result value %h kind %0d pay %b last %b st %0d pos %0d",
                             $realtime, got.value, got.kind, got.is_payload, got.last,
                             got.status, got.position);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch on result %0d", $realtime, results_seen);
                        $display("  expected value %h kind %0d pay %b last %b st %0d pos %0d",
                                 want.value, want.kind, want.is_payload, want.last,
                                 want.status, want.position);
                        $display("  actual   value %h kind %0d pay %b last %b st %0d pos %0d",
                                 got.value, got.kind, got.is_payload, got.last,
                                 got.status, got.position);
                    end
                end
            end
        end
        // random backpressure on the result channel
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no request moved for %0d cycles, %0d results outstanding",
                 $realtime, STALL_LIMIT, pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------

    // raw bytes at both extremes
    task automatic test_raw_bytes();
        send_be(KIND_BYTE, 64'h00, 1);
        send_be(KIND_BYTE, 64'hff, 1);
    endtask

    // signed varint -1 and most negative, unsigned varints of one and two bytes
    task automatic test_varints();
        send_be(KIND_U29_S, 64'hffff_ffff, 4);
        send_be(KIND_U29_S, 64'hc080_8000, 4);
        send_be(KIND_U29_U, 64'h7f, 1);
        send_be(KIND_U29_U, 64'hff00, 2);
    endtask

    // most negative int32 and largest u32, with random kinds on later bytes
    task automatic test_words();
        send_be(KIND_INT32, 64'h8000_0000, 4);
        send_be(KIND_U32, 64'hffff_ffff, 4);
    endtask

    // empty string header ends the field, one-byte string with u32 length
    task automatic test_strings();
        send_be(KIND_STR_U29, 64'h00, 1);
        send_be(KIND_STR_U32, 64'h0000_0001, 4);
        send_req(8'ha5, KIND_DOUBLE, 1'b0);
    endtask

    // end of data while idle, and in the middle of a varint
    task automatic test_end_of_data();
        send_req(8'h5a, KIND_STR_U32, 1'b1);
        send_req(8'h80, KIND_U29_U, 1'b0);
        send_req(8'h00, KIND_STR_U32, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // random stream
    // ------------------------------------------------------------------------

    // one field with random content, sometimes cut short by end of data
    task automatic send_random_field();
        kind_t  k;
        value_t hdr;
        int     n;
        int     plen;
        int     total;
        int     cut;
        int     sent;

        k    = kind_t'($urandom_range(7));
        hdr  = {$urandom, $urandom};
        n    = 1;
        plen = 0;
        case (k)
            KIND_U29_S, KIND_U29_U:
            begin
                // continuation bits set on all but the final byte
                n = $urandom_range(1, 4);
                for (int j = 0; j < n; j++)
                begin
                    if (j < n - 1)
                        hdr[(n-1-j)*8 + 7] = 1'b1;
                    else if (j < 3)
                        hdr[(n-1-j)*8 + 7] = 1'b0;
                end
            end
            KIND_INT32, KIND_U32:
            begin
                n = 4;
                case ($urandom_range(7))
                    0:       hdr = 64'h0;
                    1:       hdr = 64'hffff_ffff;
                    2:       hdr = 64'h8000_0000;
                    3:       hdr = 64'h7fff_ffff;
                    default: hdr = hdr;
                endcase
            end
            KIND_DOUBLE:
                n = 8;
            KIND_STR_U29, KIND_STR_U32:
            begin
                // short strings mostly, a few long enough for a two-byte length
                plen = ($urandom_range(15) == 0) ? $urandom_range(100, 180)
                                                 : $urandom_range(0, 8);
                if (k == KIND_STR_U32)
                begin
                    n   = 4;
                    hdr = value_t'(plen);
                end
                else if ((plen >= 128) || ($urandom_range(3) == 0))
                begin
                    // two-byte form, also a non-minimal one for short lengths
                    n   = 2;
                    hdr = value_t'({1'b1, 7'(plen >> 7), 1'b0, 7'(plen)});
                end
                else
                begin
                    n   = 1;
                    hdr = value_t'(plen);
                end
                if (plen > longest_string)
                    longest_string = plen;
            end
            default:
                n = 1;
        endcase

        total = n + plen;
        cut   = total;
        if ((total > 1) && ($urandom_range(99) < 8))
            cut = $urandom_range(1, total - 1);

        sent = 0;
        for (int i = n - 1; (i >= 0) && (sent < cut); i--)
        begin
            send_req(hdr[i*8 +: 8], (i == n - 1) ? k : kind_t'($urandom_range(7)), 1'b0);
            sent++;
        end
        while (sent < cut)
        begin
            send_req(byte_t'($urandom), kind_t'($urandom_range(7)), 1'b0);
            sent++;
        end
        if (cut < total)
            send_req(byte_t'($urandom), kind_t'($urandom_range(7)), 1'b1);
    endtask

    // random fields with a little end-of-data noise between them
    task automatic test_random_stream(input int count);
        int stop_at;

        stop_at = requests_sent + count;
        while (requests_sent < stop_at)
        begin
            if ($urandom_range(99) < 3)
                send_req(byte_t'($urandom), kind_t'($urandom_range(7)), 1'b1);
            else
                send_random_field();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------------
    initial
    begin
        // request side known from time zero; result ready follows from the first edge
        rst_n               <= 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= '0;
        byte_ch.field_kind  <= KIND_BYTE;
        byte_ch.end_of_data <= 1'b0;

        // model starts from the reset state
        dec_phase     = PH_IDLE;
        dec_count     = '0;
        dec_acc       = '0;
        dec_remaining = '0;
        dec_kind      = KIND_BYTE;
        dec_pos       = '0;

        requests_sent  = 0;
        results_seen   = 0;
        payload_seen   = 0;
        short_seen     = 0;
        idle_eod_seen  = 0;
        longest_string = 0;
        mismatches     = 0;

        // sender idles less than the receiver first
        send_idle_pct = 35;
        recv_idle_pct = 50;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_raw_bytes();
        test_varints();
        test_words();
        test_strings();
        test_end_of_data();
        test_random_stream(RANDOM_ITEMS);

        // then the other way round
        send_idle_pct = 50;
        recv_idle_pct = 35;
        test_random_stream(RANDOM_ITEMS);

        // then full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(RANDOM_ITEMS);

        byte_ch.valid <= 1'b0;

        // drain: the watchdog catches a block that never delivers
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests and %0d results: %0d payload bytes, strings up to %0d bytes",
                 requests_sent, results_seen, payload_seen, longest_string);
        $display("%0d fields cut short, %0d end-of-data requests while idle, %0d mismatches",
                 short_seen, idle_eod_seen, mismatches);
        if (pending_results.size() != 0)
            $display("%0d expected results never arrived", pending_results.size());

        if ((mismatches == 0) && (pending_results.size() == 0))
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
